// File: hw/rtl/dual_pid_drive_controller_top_defines.svh
// assertion macros shared by the dual pid drive controller rtl
// depends on nothing; expects clk and rst_n in the including module
`ifndef DUAL_PID_DRIVE_CONTROLLER_TOP_DEFINES_SVH
`define DUAL_PID_DRIVE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DPID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpid assertion failed");

// next-cycle implication, checked out of reset
`define DPID_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpid assertion failed");

`endif

// File: hw/rtl/dpid_pkg.sv
// widths, reset gains and register indexes of the dual pid drive controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpid_pkg;

    // field widths
    localparam int POS_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int CMD_W      = 16;
    localparam int CFG_IDX_W  = 3;

    // internal widths
    localparam int LAT_ERR_W  = POS_W + 1;
    localparam int LAT_DER_W  = LAT_ERR_W + 1;
    localparam int TURN_ERR_W = POS_W + 2;
    localparam int TURN_DER_W = TURN_ERR_W + 1;
    localparam int SUM_W      = 40;
    localparam int SUM_LO_W   = 20;
    localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
    localparam int ITERM_W    = 64;
    localparam int ICLAMP_W   = 54;
    localparam int LAT_PD_W   = 52;
    localparam int TURN_PD_W  = 53;
    localparam int LAT_TOT_W  = 55;
    localparam int FINAL_W    = 56;
    localparam int FRAC_DROP  = 8;
    localparam int STAGES     = 7;

    // reset gains, unsigned q8.16
    localparam logic [GAIN_W-1:0] LATERAL_KP_RST = 24'd5243;
    localparam logic [GAIN_W-1:0] LATERAL_KI_RST = 24'd0;
    localparam logic [GAIN_W-1:0] LATERAL_KD_RST = 24'd45875;
    localparam logic [GAIN_W-1:0] TURN_KP_RST    = 24'd655;
    localparam logic [GAIN_W-1:0] TURN_KD_RST    = 24'd66;

    // integral term limit, q.16
    localparam logic signed [ITERM_W-1:0] ITERM_LIM = 64'sd4503599627370496;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_LATERAL_KP = 3'd0,
        IDX_LATERAL_KI = 3'd1,
        IDX_LATERAL_KD = 3'd2,
        IDX_TURN_KP    = 3'd3,
        IDX_TURN_KD    = 3'd4
    } cfg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/dual_pid_drive_controller_top.sv
// dual pid differential drive controller, seven stage pipeline
// depends on dpid_pkg and dual_pid_drive_controller_top_defines.svh
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, four position words   | to block
//   out     | out_valid, out_ready, two command words   | from block
//   cfg     | cfg_write, cfg_index, cfg_data            | to block
//
// one word accepted per cycle unless held; a result is offered from the stage 7 register
// the seven pipeline stages advance together, held only while the output
// register carries a word that is not taken
// reset zeroes the integrator and the last error registers and loads
// the default gains; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

`include "dual_pid_drive_controller_top_defines.svh"

module dual_pid_drive_controller_top
    import dpid_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [POS_W-1:0]  left_position,
    input  wire logic signed [POS_W-1:0]  right_position,
    input  wire logic signed [POS_W-1:0]  distance_target,
    input  wire logic signed [POS_W-1:0]  turn_target,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [CMD_W-1:0]       left_command,
    output logic signed [CMD_W-1:0]       right_command,

    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [GAIN_W-1:0]        cfg_data
);

    // gain registers
    logic [GAIN_W-1:0] lateral_kp_reg, lateral_ki_reg, lateral_kd_reg;
    logic [GAIN_W-1:0] turn_kp_reg, turn_kd_reg;

    // loop state
    logic signed [LAT_ERR_W-1:0]  last_lat_err_reg;
    logic signed [TURN_ERR_W-1:0] last_turn_err_reg;
    logic signed [SUM_W-1:0]      sum_reg;

    // pipeline control
    logic [STAGES-1:0] valid_reg;
    logic              adv;

    // stage 1: input words
    logic signed [POS_W-1:0] s1_left_reg, s1_right_reg, s1_dist_reg, s1_turn_reg;

    // stage 2: errors and previous errors
    logic signed [LAT_ERR_W-1:0]  s2_lat_err_reg, s2_lat_prev_reg;
    logic signed [TURN_ERR_W-1:0] s2_turn_err_reg, s2_turn_prev_reg;

    // stage 3: errors, derivatives, integrator
    logic signed [LAT_ERR_W-1:0]  s3_lat_err_reg;
    logic signed [LAT_DER_W-1:0]  s3_lat_der_reg;
    logic signed [TURN_ERR_W-1:0] s3_turn_err_reg;
    logic signed [TURN_DER_W-1:0] s3_turn_der_reg;
    logic signed [SUM_W-1:0]      s3_sum_reg;

    // stage 4: products
    logic signed [LAT_ERR_W+GAIN_W:0]  s4_lat_p_reg;
    logic signed [LAT_DER_W+GAIN_W:0]  s4_lat_d_reg;
    logic signed [SUM_HI_W+GAIN_W:0]   s4_int_hi_reg;
    logic [SUM_LO_W+GAIN_W-1:0]        s4_int_lo_reg;
    logic signed [TURN_ERR_W+GAIN_W:0] s4_turn_p_reg;
    logic signed [TURN_DER_W+GAIN_W:0] s4_turn_d_reg;

    // stage 5: partial sums
    logic signed [ITERM_W-1:0]   s5_iterm_reg;
    logic signed [LAT_PD_W-1:0]  s5_lat_pd_reg;
    logic signed [TURN_PD_W-1:0] s5_turn_pd_reg;

    // stage 6: lateral total and turn term
    logic signed [LAT_TOT_W-1:0] s6_lat_reg;
    logic signed [TURN_PD_W-1:0] s6_turn_reg;

    // stage 7: output word
    logic signed [CMD_W-1:0] out_left_reg, out_right_reg;

    // combinational nets
    logic signed [LAT_ERR_W-1:0]  pos_sum;
    logic signed [LAT_ERR_W-1:0]  avg;
    logic signed [LAT_ERR_W-1:0]  lat_err_next;
    logic signed [TURN_ERR_W-1:0] turn_err_next;
    logic signed [LAT_DER_W-1:0]  lat_der_next;
    logic signed [TURN_DER_W-1:0] turn_der_next;
    logic signed [SUM_W:0]        sum_wide;
    logic signed [SUM_W-1:0]      sum_next;
    logic signed [ICLAMP_W-1:0]   iterm_clamp;
    logic signed [FINAL_W-1:0]    total_left, total_right;
    logic signed [CMD_W-1:0]      cmd_left_next, cmd_right_next;

    // truncation and saturation to q7.8; the rounding bias is added by the caller
    function automatic logic signed [CMD_W-1:0] to_cmd(input logic signed [FINAL_W-1:0] v);
        logic signed [FINAL_W-FRAC_DROP-1:0] q8;
        logic                                fits;
        q8   = v[FINAL_W-1:FRAC_DROP];
        fits = (q8[FINAL_W-FRAC_DROP-1:CMD_W-1] == '0)
            || (q8[FINAL_W-FRAC_DROP-1:CMD_W-1] == '1);
        priority if (fits)
            to_cmd = q8[CMD_W-1:0];
        else if (q8[FINAL_W-FRAC_DROP-1])
            to_cmd = {1'b1, {(CMD_W-1){1'b0}}};
        else
            to_cmd = {1'b0, {(CMD_W-1){1'b1}}};
    endfunction

    // the whole pipeline moves unless the output word is held
    assign adv       = !valid_reg[STAGES-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[STAGES-1];
    assign left_command  = out_left_reg;
    assign right_command = out_right_reg;

    // configuration writes, out of range indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lateral_kp_reg <= LATERAL_KP_RST;
            lateral_ki_reg <= LATERAL_KI_RST;
            lateral_kd_reg <= LATERAL_KD_RST;
            turn_kp_reg    <= TURN_KP_RST;
            turn_kd_reg    <= TURN_KD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                IDX_LATERAL_KP: lateral_kp_reg <= cfg_data;
                IDX_LATERAL_KI: lateral_ki_reg <= cfg_data;
                IDX_LATERAL_KD: lateral_kd_reg <= cfg_data;
                IDX_TURN_KP:    turn_kp_reg    <= cfg_data;
                IDX_TURN_KD:    turn_kd_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // error terms, average truncated toward zero
    always_comb
    begin
        pos_sum       = LAT_ERR_W'(s1_left_reg) + LAT_ERR_W'(s1_right_reg);
        avg           = (pos_sum + LAT_ERR_W'($signed({1'b0, pos_sum[LAT_ERR_W-1]}))) >>> 1;
        lat_err_next  = avg - LAT_ERR_W'(s1_dist_reg);
        turn_err_next = TURN_ERR_W'(s1_left_reg) - TURN_ERR_W'(s1_right_reg)
                      - TURN_ERR_W'(s1_turn_reg);
    end

    // derivatives and saturating integrator
    always_comb
    begin
        lat_der_next  = LAT_DER_W'(s2_lat_err_reg) - LAT_DER_W'(s2_lat_prev_reg);
        turn_der_next = TURN_DER_W'(s2_turn_err_reg) - TURN_DER_W'(s2_turn_prev_reg);
        sum_wide      = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(s2_lat_err_reg);
        priority if (sum_wide[SUM_W] == sum_wide[SUM_W-1])
            sum_next = sum_wide[SUM_W-1:0];
        else if (sum_wide[SUM_W])
            sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        else
            sum_next = {1'b0, {(SUM_W-1){1'b1}}};
    end

    // integral term clamp
    always_comb
    begin
        priority if (s5_iterm_reg > ITERM_LIM)
            iterm_clamp = ICLAMP_W'(ITERM_LIM);
        else if (s5_iterm_reg < -ITERM_LIM)
            iterm_clamp = ICLAMP_W'(-ITERM_LIM);
        else
            iterm_clamp = s5_iterm_reg[ICLAMP_W-1:0];
    end

    // side sums with rounding bias
    always_comb
    begin
        total_left  = FINAL_W'(s6_lat_reg) + FINAL_W'(s6_turn_reg)
                    + FINAL_W'(1 << (FRAC_DROP - 1));
        total_right = FINAL_W'(s6_lat_reg) - FINAL_W'(s6_turn_reg)
                    + FINAL_W'(1 << (FRAC_DROP - 1));
        cmd_left_next  = to_cmd(total_left);
        cmd_right_next = to_cmd(total_right);
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            last_lat_err_reg  <= '0;
            last_turn_err_reg <= '0;
            sum_reg           <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
            if (valid_reg[0])
            begin
                last_lat_err_reg  <= lat_err_next;
                last_turn_err_reg <= turn_err_next;
            end
            if (valid_reg[1])
            begin
                sum_reg <= sum_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_left_reg  <= left_position;
            s1_right_reg <= right_position;
            s1_dist_reg  <= distance_target;
            s1_turn_reg  <= turn_target;
            // stage 2
            s2_lat_err_reg   <= lat_err_next;
            s2_lat_prev_reg  <= last_lat_err_reg;
            s2_turn_err_reg  <= turn_err_next;
            s2_turn_prev_reg <= last_turn_err_reg;
            // stage 3
            s3_lat_err_reg  <= s2_lat_err_reg;
            s3_lat_der_reg  <= lat_der_next;
            s3_turn_err_reg <= s2_turn_err_reg;
            s3_turn_der_reg <= turn_der_next;
            s3_sum_reg      <= sum_next;
            // stage 4: integral product split into high and low halves
            s4_lat_p_reg  <= s3_lat_err_reg * $signed({1'b0, lateral_kp_reg});
            s4_lat_d_reg  <= s3_lat_der_reg * $signed({1'b0, lateral_kd_reg});
            s4_int_hi_reg <= $signed(s3_sum_reg[SUM_W-1:SUM_LO_W])
                           * $signed({1'b0, lateral_ki_reg});
            s4_int_lo_reg <= s3_sum_reg[SUM_LO_W-1:0] * lateral_ki_reg;
            s4_turn_p_reg <= s3_turn_err_reg * $signed({1'b0, turn_kp_reg});
            s4_turn_d_reg <= s3_turn_der_reg * $signed({1'b0, turn_kd_reg});
            // stage 5
            s5_iterm_reg   <= (ITERM_W'(s4_int_hi_reg) <<< SUM_LO_W)
                            + $signed(ITERM_W'(s4_int_lo_reg));
            s5_lat_pd_reg  <= LAT_PD_W'(s4_lat_p_reg) + LAT_PD_W'(s4_lat_d_reg);
            s5_turn_pd_reg <= TURN_PD_W'(s4_turn_p_reg) + TURN_PD_W'(s4_turn_d_reg);
            // stage 6
            s6_lat_reg  <= LAT_TOT_W'(iterm_clamp) + LAT_TOT_W'(s5_lat_pd_reg);
            s6_turn_reg <= s5_turn_pd_reg;
            // stage 7
            out_left_reg  <= cmd_left_next;
            out_right_reg <= cmd_right_next;
        end
    end

    // a refused input word means a held output word
    `DPID_ASSERT_IMP(a_ready_only_on_hold, !in_ready, out_valid && !out_ready)
    // integrator frozen while the pipeline is held
    `DPID_ASSERT_NXT(a_sum_held, !adv, $stable(sum_reg) && $stable(last_lat_err_reg))
    // an accepted word enters stage one
    `DPID_ASSERT_NXT(a_accept_fills, in_valid && in_ready, valid_reg[0])
    // a new output word comes from the stage before it
    `DPID_ASSERT_IMP(a_out_from_pipe, $rose(out_valid), $past(valid_reg[STAGES-2]))

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for the dual pid drive controller
// depends on dpid_pkg and dual_pid_drive_controller_top; runs directed, random and windup tests
// a bit-exact predictor of both loops computes the expected commands for every accepted word
`timescale 1ns / 1ps

module tb;
    import dpid_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = STAGES + 4;
    localparam int MAX_WAIT      = 15;
    localparam int WATCHDOG_NS   = 10_000_000;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0]       GAIN_MAX = '1;
    localparam logic [GAIN_W-1:0]       GAIN_ONE = GAIN_W'(1 << 16);

    localparam longint ACC_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< (SUM_W - 1));
    localparam longint CMD_MAX = (longint'(1) <<< (CMD_W - 1)) - 1;
    localparam longint CMD_MIN = -(longint'(1) <<< (CMD_W - 1));
    localparam longint HALF_Q8 = longint'(1) <<< (FRAC_DROP - 1);

    // one input word and one result word
    typedef struct {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] dist_tgt;
        logic signed [POS_W-1:0] turn_tgt;
    } pos_word_t;

    typedef struct {
        logic signed [CMD_W-1:0] left;
        logic signed [CMD_W-1:0] right;
    } cmd_word_t;

    typedef struct {
        logic [GAIN_W-1:0] lat_kp;
        logic [GAIN_W-1:0] lat_ki;
        logic [GAIN_W-1:0] lat_kd;
        logic [GAIN_W-1:0] trn_kp;
        logic [GAIN_W-1:0] trn_kd;
    } gain_set_t;

    typedef enum int {
        MIX_RESET,
        MIX_ZERO,
        MIX_MAX,
        MIX_FULL,
        MIX_TUNED
    } gain_mix_t;

    localparam gain_set_t RESET_GAINS = '{LATERAL_KP_RST, LATERAL_KI_RST, LATERAL_KD_RST,
                                          TURN_KP_RST, TURN_KD_RST};

    // dut signals
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [POS_W-1:0] left_position = '0;
    logic signed [POS_W-1:0] right_position = '0;
    logic signed [POS_W-1:0] distance_target = '0;
    logic signed [POS_W-1:0] turn_target = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [CMD_W-1:0] left_command;
    logic signed [CMD_W-1:0] right_command;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [GAIN_W-1:0]       cfg_data = '0;

    // predictor state
    gain_set_t gains = RESET_GAINS;
    longint    last_lat_err = 0;
    longint    last_turn_err = 0;
    longint    lat_err_sum = 0;
    cmd_word_t cmd_expect_q[$];

    // run control shared by the sender, the receiver and the tests
    int mismatches = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit tx_driving = 1'b0;
    int rx_hold_cycles = 0;

    dual_pid_drive_controller_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .left_position   (left_position),
        .right_position  (right_position),
        .distance_target (distance_target),
        .turn_target     (turn_target),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_command    (left_command),
        .right_command   (right_command),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // round q.16 to q.8 with ties toward plus infinity, then saturate
    function automatic logic signed [CMD_W-1:0] round_to_cmd(input longint q16);
        longint q8;
        q8 = (q16 + HALF_Q8) >>> FRAC_DROP;
        if (q8 > CMD_MAX)
            q8 = CMD_MAX;
        else if (q8 < CMD_MIN)
            q8 = CMD_MIN;
        return q8[CMD_W-1:0];
    endfunction

    // one control tick of both loops; updates the error history and the integrator
    function automatic cmd_word_t advance_drive_pid(input pos_word_t w);
        longint    l;
        longint    r;
        longint    lat_err;
        longint    lat_der;
        longint    iterm;
        longint    lateral;
        longint    turn_err;
        longint    turn_der;
        longint    turn_pd;
        cmd_word_t c;
        l = longint'(w.left);
        r = longint'(w.right);
        // average truncates toward zero
        lat_err = (l + r) / 2 - longint'(w.dist_tgt);
        lat_der = lat_err - last_lat_err;
        lat_err_sum = lat_err_sum + lat_err;
        if (lat_err_sum > ACC_MAX)
            lat_err_sum = ACC_MAX;
        else if (lat_err_sum < ACC_MIN)
            lat_err_sum = ACC_MIN;
        iterm = lat_err_sum * longint'(gains.lat_ki);
        if (iterm > ITERM_LIM)
            iterm = ITERM_LIM;
        else if (iterm < -ITERM_LIM)
            iterm = -ITERM_LIM;
        lateral = lat_err * longint'(gains.lat_kp) + lat_der * longint'(gains.lat_kd) + iterm;
        turn_err = l - r - longint'(w.turn_tgt);
        turn_der = turn_err - last_turn_err;
        turn_pd = turn_err * longint'(gains.trn_kp) + turn_der * longint'(gains.trn_kd);
        c.left = round_to_cmd(lateral + turn_pd);
        c.right = round_to_cmd(lateral - turn_pd);
        last_lat_err = lat_err;
        last_turn_err = turn_err;
        return c;
    endfunction

    function automatic pos_word_t mk_word(input logic signed [POS_W-1:0] l,
                                          input logic signed [POS_W-1:0] r,
                                          input logic signed [POS_W-1:0] d,
                                          input logic signed [POS_W-1:0] t);
        pos_word_t w;
        w.left = l;
        w.right = r;
        w.dist_tgt = d;
        w.turn_tgt = t;
        return w;
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic signed [POS_W-1:0] corner_value();
        case ($urandom_range(0, 4))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return '0;
            3: return '1;
            default: return POS_W'($urandom());
        endcase
    endfunction

    // mostly positions near the targets, some full range, some corners
    function automatic pos_word_t rand_word();
        pos_word_t w;
        int        pick;
        int        base;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            base = spread(1 << 20);
            w.left = POS_W'(base + spread(2048));
            w.right = POS_W'(base + spread(2048));
            w.dist_tgt = POS_W'(base + spread(2048));
            w.turn_tgt = POS_W'(spread(4096));
        end else if (pick < 90) begin
            w.left = POS_W'($urandom());
            w.right = POS_W'($urandom());
            w.dist_tgt = POS_W'($urandom());
            w.turn_tgt = POS_W'($urandom());
        end else begin
            w.left = corner_value();
            w.right = corner_value();
            w.dist_tgt = corner_value();
            w.turn_tgt = corner_value();
        end
        return w;
    endfunction

    function automatic gain_set_t rand_gain_set(input gain_mix_t mix);
        gain_set_t g;
        case (mix)
            MIX_RESET: g = RESET_GAINS;
            MIX_ZERO:  g = '{'0, '0, '0, '0, '0};
            MIX_MAX:   g = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX};
            MIX_FULL:  g = '{GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()),
                             GAIN_W'($urandom()), GAIN_W'($urandom())};
            default:
            begin
                g.lat_kp = GAIN_W'($urandom_range(0, 1 << 16));
                g.lat_ki = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
                g.lat_kd = GAIN_W'($urandom_range(0, 1 << 17));
                g.trn_kp = GAIN_W'($urandom_range(0, 1 << 12));
                g.trn_kd = GAIN_W'($urandom_range(0, 1 << 10));
            end
        endcase
        return g;
    endfunction

    // offer one word, after a random gap when sender idles are on, and wait for it to be taken
    task automatic send_word(input pos_word_t w);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            if (tx_driving)
                in_valid <= 1'b0;
            tx_driving = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_position <= w.left;
        right_position <= w.right;
        distance_target <= w.dist_tgt;
        turn_target <= w.turn_tgt;
        tx_driving = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        cmd_expect_q.push_back(advance_drive_pid(w));
    endtask

    // drop valid, wait for every outstanding command, let the pipeline settle
    task automatic wait_quiet();
        if (tx_driving)
            in_valid <= 1'b0;
        tx_driving = 1'b0;
        while (cmd_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            IDX_LATERAL_KP: gains.lat_kp = val;
            IDX_LATERAL_KI: gains.lat_ki = val;
            IDX_LATERAL_KD: gains.lat_kd = val;
            IDX_TURN_KP:    gains.trn_kp = val;
            IDX_TURN_KD:    gains.trn_kd = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_gains(input gain_set_t g);
        wait_quiet();
        write_reg(IDX_LATERAL_KP, g.lat_kp);
        write_reg(IDX_LATERAL_KI, g.lat_ki);
        write_reg(IDX_LATERAL_KD, g.lat_kd);
        write_reg(IDX_TURN_KP, g.trn_kp);
        write_reg(IDX_TURN_KD, g.trn_kd);
        cfg_write <= 1'b0;
    endtask

    // corners, truncation of the average, rounding ties, output saturation
    task automatic test_directed_cases();
        // reset gains with large jumps between words
        send_word(mk_word(0, 0, 0, 0));
        send_word(mk_word(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_word(mk_word(POS_MIN, POS_MIN, POS_MIN, POS_MIN));
        send_word(mk_word(POS_MAX, POS_MIN, POS_MIN, POS_MAX));
        send_word(mk_word(POS_MIN, POS_MAX, POS_MAX, POS_MIN));
        // unity lateral gain shows truncation toward zero of odd sums
        program_gains('{GAIN_ONE, '0, '0, '0, '0});
        send_word(mk_word(-3, 0, 0, 0));
        send_word(mk_word(0, 3, 0, 0));
        send_word(mk_word(POS_MIN, POS_MIN + 1, 0, 0));
        // smallest gains put the sums on half-lsb ties
        program_gains('{1, '0, '0, 1, '0});
        send_word(mk_word(128, 128, 0, 0));
        send_word(mk_word(-128, -128, 0, 0));
        send_word(mk_word(-129, -129, 0, 0));
        send_word(mk_word(64, -64, 0, 0));
        send_word(mk_word(-64, 64, 0, 0));
        // all gains at full scale drive both commands into saturation
        program_gains('{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX});
        send_word(mk_word(POS_MAX, POS_MIN, POS_MIN, POS_MIN));
        send_word(mk_word(POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        send_word(mk_word(POS_MIN, POS_MIN, POS_MAX, POS_MAX));
    endtask

    // writes to unused indexes must leave every gain alone
    task automatic test_out_of_range_index();
        program_gains(RESET_GAINS);
        @(posedge clk);
        for (int i = int'(IDX_TURN_KD) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(i[CFG_IDX_W-1:0], GAIN_W'($urandom()));
        cfg_write <= 1'b0;
        repeat (3) send_word(rand_word());
    endtask

    // phases of random words under different gain sets and idle patterns
    task automatic test_random_gain_sets();
        gain_mix_t mix;
        for (int phase = 0; phase < 10; phase++) begin
            if (phase <= int'(MIX_TUNED))
                mix = gain_mix_t'(phase);
            else
                mix = gain_mix_t'($urandom_range(0, int'(MIX_TUNED)));
            program_gains(rand_gain_set(mix));
            tx_idle_on = (phase % 4 != 3);
            rx_idle_on = (phase % 3 != 2);
            repeat (160) send_word(rand_word());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        program_gains(rand_gain_set(MIX_TUNED));
        tx_idle_on = 1'b0;
        rx_hold_cycles = 150;
        repeat (60) send_word(rand_word());
        tx_idle_on = 1'b1;
    endtask

    // sender pauses until every command is back, then resumes
    task automatic test_drain_pause();
        repeat (25) send_word(rand_word());
        wait_quiet();
        repeat (40) @(posedge clk);
        repeat (25) send_word(rand_word());
    endtask

    // wind the integrator both ways and hit the integral term clamp
    task automatic test_integrator_windup();
        pos_word_t push_up;
        pos_word_t push_down;
        push_up = mk_word(POS_MAX, POS_MAX, POS_MIN, 0);
        push_down = mk_word(POS_MIN, POS_MIN, POS_MAX, 0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        // full-scale integral gain also hits the integral term clamp
        program_gains('{LATERAL_KP_RST, GAIN_MAX, LATERAL_KD_RST, TURN_KP_RST, TURN_KD_RST});
        repeat (40) send_word(push_up);
        // integral only with unity lsb gain makes the sum visible near zero
        program_gains('{'0, 1, '0, '0, '0});
        repeat (80) send_word(push_down);
        repeat (20) send_word(push_up);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (20) send_word(rand_word());
    endtask

    // stimulus and final verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_out_of_range_index();
        test_random_gain_sets();
        test_output_backpressure();
        test_drain_pause();
        test_integrator_windup();
        wait_quiet();
        if (mismatches == 0)
            $display("PASS dual_pid_drive_controller_top");
        else
            $display("FAIL dual_pid_drive_controller_top");
        $finish;
    end

    // receiver: random stalls, long hold on request, compare every word taken
    initial begin : rx_proc
        int        stall;
        cmd_word_t want;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (cmd_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected command word: left %0d right %0d",
                                 left_command, right_command);
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (left_command !== want.left || right_command !== want.right) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("command mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                     want.left, left_command, want.right, right_command);
                    end
                end
                stall = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        #WATCHDOG_NS;
        $display("FAIL dual_pid_drive_controller_top");
        $finish;
    end

endmodule
